@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the cave automaton block.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define CAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cas_pkg.sv @@
// Package for the cave automaton step block: item types, register codes,
// window masks and the cell rule. Depends on nothing.
package cas_pkg;

  // Default grid limits for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  // Grid size registers
  localparam int       MIN_DIM   = 3;
  localparam logic [7:0] RESET_DIM = 8'd100;
  localparam int       CFG_AW    = 3;
  localparam int       CFG_DW    = 32;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cas_reg_t;

  // Depth of the queue between front and back
  localparam int QDEPTH = 4;

  // Width of the reported coordinates
  localparam int POS_W = 7;

  // Window bit 3*column + row; column 0 is the oldest (left), row 0 the top
  localparam logic [8:0] MASK_LEFT   = 9'h007;
  localparam logic [8:0] MASK_RIGHT  = 9'h1C0;
  localparam logic [8:0] MASK_TOP    = 9'h049;
  localparam logic [8:0] MASK_BOTTOM = 9'h124;
  localparam logic [8:0] MASK_CENTRE = 9'h010;

  // Cell rule thresholds
  localparam logic [3:0] STAY_ONE  = 4'd1;
  localparam logic [3:0] STAY_MIN  = 4'd4;
  localparam logic [3:0] BIRTH_MIN = 4'd5;

  typedef struct packed {
    logic cell_free;
    logic pad_item;
  } cas_in_t;

  typedef struct packed {
    logic             next_free;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_cell;
  } cas_out_t;

  // One window column handed from front to back
  typedef struct packed {
    logic [2:0] bits;   // bit 0 top, bit 1 middle, bit 2 bottom (newest)
    logic       emit;   // this item completes a cell's window
  } cas_col_t;

  function automatic logic [3:0] cas_popcount(input logic [8:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 9; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

  function automatic logic cas_rule(input logic centre, input logic [3:0] n);
    logic r;
    if (centre) begin
      r = (n == STAY_ONE) || (n >= STAY_MIN);
    end else begin
      r = (n >= BIRTH_MIN);
    end
    return r;
  endfunction

endpackage

@@ rtl/cas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module cas_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cas_queue.sv @@
// Short queue of window columns between the front and the back.
// Depends on cas_pkg.
module cas_queue import cas_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  cas_col_t                     wr_entry,
  input  logic                         pop,
  output logic                         valid,
  output cas_col_t                     rd_entry,
  output logic [$clog2(QDEPTH+1)-1:0]  count
);

  localparam int PW  = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH+1);

  cas_col_t        entries [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;

  assign valid    = (count != '0);
  assign rd_entry = entries[rd_ptr];

  // Storage; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

endmodule

@@ rtl/cas_front.sv @@
// Front of the cave automaton: takes cells, tracks the input position,
// reads and updates the two line stores, and queues one window column per item.
// Depends on cas_pkg and cas_ram.
module cas_front import cas_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     h,
  input  logic                                push,
  input  cas_in_t                             cell_item,
  output logic                                full,
  input  logic [$clog2(QDEPTH+1)-1:0]         q_count,
  output logic                                q_push,
  output cas_col_t                            q_entry
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int RW  = $clog2(MAX_HEIGHT+2);
  localparam int QCW = $clog2(QDEPTH+1);

  // Input position
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [WW-1:0] col_inc;
  logic          accept;
  logic          emit;
  logic          frame_end;
  logic          v;

  // Stage that meets the line store read data
  logic          s1_valid;
  logic          s1_v;
  logic [CW-1:0] s1_col;
  logic          s1_emit;
  logic          byp_hit;
  logic          byp_a;
  logic          byp_b;
  logic          rd_a;
  logic          rd_b;
  logic          top;
  logic          mid;

  // Room is reserved for the item in flight so the stage never stalls
  assign full    = (QCW'(q_count) + QCW'(s1_valid)) >= QCW'(QDEPTH);
  assign accept  = push && !full;
  assign v       = cell_item.cell_free & ~cell_item.pad_item;
  assign col_inc = WW'(in_col) + WW'(1);

  // Results start with the second cell of row one; the frame's last result
  // comes with the first item of row h+1
  assign emit      = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));
  assign frame_end = (in_row == (RW'(h) + RW'(1))) && (in_col == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
    end else begin
      priority if (restart || (accept && frame_end)) begin
        in_col <= '0;
        in_row <= '0;
      end else if (accept) begin
        if (col_inc >= w) begin
          in_col <= '0;
          in_row <= in_row + RW'(1);
        end else begin
          in_col <= col_inc[CW-1:0];
        end
      end
    end
  end

  // Line stores: a holds the row above, b the row above that
  cas_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_v),
    .raddr (in_col),
    .rdata (rd_a)
  );

  cas_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (mid),
    .raddr (in_col),
    .rdata (rd_b)
  );

  // Forward the write in progress when the next item reads the same column
  assign mid = byp_hit ? byp_a : rd_a;
  assign top = byp_hit ? byp_b : rd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v    <= v;
      s1_col  <= in_col;
      s1_emit <= emit;
      byp_hit <= s1_valid && (s1_col == in_col);
      byp_a   <= s1_v;
      byp_b   <= mid;
    end
  end

  assign q_push        = s1_valid;
  assign q_entry.bits  = {s1_v, mid, top};
  assign q_entry.emit  = s1_emit;

endmodule

@@ rtl/cas_back.sv @@
// Back of the cave automaton: shifts columns into the 3x3 window, applies the
// cell rule with edge masking, tracks the emitted position, holds the result.
// Depends on cas_pkg.
module cas_back import cas_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  h,
  input  logic                             q_valid,
  input  cas_col_t                         q_entry,
  output logic                             q_pop,
  input  logic                             pop,
  output logic                             empty,
  output cas_out_t                         result
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int ERW = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT+1);

  logic [8:0]     window;
  logic [CW-1:0]  emit_col;
  logic [ERW-1:0] emit_row;
  logic           out_valid;

  logic [8:0]     win_new;
  logic [8:0]     win_masked;
  logic [3:0]     n;
  logic           nf;
  logic           first_col;
  logic           last_col;
  logic           first_row;
  logic           last_row;
  logic           is_last;
  logic           do_emit;
  logic [31:0]    row32;
  logic [31:0]    col32;

  // A column that makes no result moves on regardless of the output side
  assign q_pop   = q_valid && (!q_entry.emit || !out_valid || pop);
  assign do_emit = q_pop && q_entry.emit;
  assign empty   = !out_valid;

  assign first_col = (emit_col == '0);
  assign last_col  = (WW'(emit_col) + WW'(1)) >= w;
  assign first_row = (emit_row == '0);
  assign last_row  = (HW'(emit_row) + HW'(1)) >= h;
  assign is_last   = last_col && last_row;

  // Neighbour count with cells outside the grid masked off
  always_comb begin
    win_new    = {q_entry.bits, window[8:3]};
    win_masked = win_new & ~MASK_CENTRE;
    if (first_col) win_masked = win_masked & ~MASK_LEFT;
    if (last_col)  win_masked = win_masked & ~MASK_RIGHT;
    if (first_row) win_masked = win_masked & ~MASK_TOP;
    if (last_row)  win_masked = win_masked & ~MASK_BOTTOM;
    n  = cas_popcount(win_masked);
    nf = cas_rule(win_new[4], n);
  end

  assign row32 = 32'(emit_row);
  assign col32 = 32'(emit_col);

  // Window and emit position
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      emit_col <= '0;
      emit_row <= '0;
    end else begin
      if (q_pop) begin
        window <= win_new;
      end
      priority if (restart || (do_emit && is_last)) begin
        emit_col <= '0;
        emit_row <= '0;
      end else if (do_emit) begin
        if (last_col) begin
          emit_col <= '0;
          emit_row <= emit_row + ERW'(1);
        end else begin
          emit_col <= emit_col + CW'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      result.next_free <= nf;
      result.out_row   <= row32[POS_W-1:0];
      result.out_col   <= col32[POS_W-1:0];
      result.last_cell <= is_last;
    end
  end

endmodule

@@ rtl/cave_automaton_step_core.sv @@
// Cave automaton step: one generation of a Moore-neighbourhood cave rule over
// a raster-order grid. Input channel: push/full, one cell per item (cell_free,
// pad_item; a pad counts as solid). Result channel: empty/pop, results in
// raster order with row, column and a last-of-frame mark.
// A frame is grid_width*grid_height cells followed by grid_width+1 pads; the
// result for cell k comes out with item k+grid_width+1, the first grid_width+1
// items of a frame make none. While full stays low, one item per cycle is
// sustained: the line store read is a single registered RAM access per item
// and the rule is one stage. An accepted item's result, if any, passes the
// front stage register, the column queue and the output register. A stalled
// pop holds the result and stops the back at the next column that makes a
// result; the front keeps filling the four-entry column queue, and full
// rises once the queued columns plus the item in flight reach four.
// Grid size: APB registers grid_width (0x0) and grid_height (0x4), reset 100,
// clamped to 3..MAX. A write restarts the frame; write only while idle.
// Reset empties the pipeline and restarts the frame; line stores need no
// clearing since rows and columns outside the current frame are masked.
// Depends on cas_pkg, cas_front, cas_queue and cas_back.
module cave_automaton_step_core import cas_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  // Cells in
  input  logic              push,
  output logic              full,
  input  cas_in_t           cell_item,
  // Results out
  output logic              empty,
  input  logic              pop,
  output cas_out_t          result
);

  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int HW  = $clog2(MAX_HEIGHT+1);
  localparam int QCW = $clog2(QDEPTH+1);

  logic [7:0]     grid_width;
  logic [7:0]     grid_height;
  logic           cfg_wr;
  cas_reg_t       reg_sel;
  logic [31:0]    w_raw;
  logic [31:0]    h_raw;
  logic [31:0]    w_clamp;
  logic [31:0]    h_clamp;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;

  logic           q_push;
  cas_col_t       q_wr_entry;
  logic           q_pop;
  logic           q_valid;
  cas_col_t       q_rd_entry;
  logic [QCW-1:0] q_count;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = cas_reg_t'(paddr[CFG_AW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RESET_DIM;
      grid_height <= RESET_DIM;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GRID_WIDTH:  grid_width  <= pwdata[7:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[7:0];
        default:         grid_width  <= grid_width;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_WIDTH:  prdata = CFG_DW'(grid_width);
      REG_GRID_HEIGHT: prdata = CFG_DW'(grid_height);
      default:         prdata = '0;
    endcase
  end

  // Dimensions in use, clamped to the supported range
  always_comb begin
    w_raw = 32'(grid_width);
    h_raw = 32'(grid_height);
    if (w_raw < 32'(MIN_DIM)) begin
      w_clamp = 32'(MIN_DIM);
    end else if (w_raw > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = w_raw;
    end
    if (h_raw < 32'(MIN_DIM)) begin
      h_clamp = 32'(MIN_DIM);
    end else if (h_raw > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT);
    end else begin
      h_clamp = h_raw;
    end
  end

  assign w = w_clamp[WW-1:0];
  assign h = h_clamp[HW-1:0];

  cas_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .w         (w),
    .h         (h),
    .push      (push),
    .cell_item (cell_item),
    .full      (full),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  cas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .valid    (q_valid),
    .rd_entry (q_rd_entry),
    .count    (q_count)
  );

  cas_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .w       (w),
    .h       (h),
    .q_valid (q_valid),
    .q_entry (q_rd_entry),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

@@ rtl/cas_checker.sv @@
// Port-level checks for cave_automaton_step_core, bound to the top level.
// Depends on cas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cas_checker import cas_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     psel,
  input logic     penable,
  input logic     pwrite,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input cas_out_t result
);

  logic             taken;
  logic             origin;
  logic [POS_W-1:0] prev_row;
  logic [POS_W-1:0] prev_col;

  assign taken = pop && !empty;

  // Next result starts a frame after reset, a register write or a last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= 1'b1;
    end else if (psel && penable && pwrite) begin
      origin <= 1'b1;
    end else if (taken) begin
      origin <= result.last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (taken) begin
      prev_row <= result.out_row;
      prev_col <= result.out_col;
    end
  end

  `CAS_ASSERT(a_frame_origin, taken && origin |-> result.out_row == '0 && result.out_col == '0, "frame does not start at the origin")
  `CAS_ASSERT(a_raster_order, taken && !origin && result.out_col != '0 |-> result.out_row == prev_row && result.out_col == POS_W'(prev_col + POS_W'(1)), "result out of raster order")
  `CAS_ASSERT(a_result_held, !empty && !pop |=> !empty && $stable(result), "waiting result changed")
  `CAS_ASSERT_ALWAYS(a_reset_idle, rst |=> empty && !full, "block not idle after reset")

endmodule

bind cave_automaton_step_core cas_checker u_cas_checker (.*);
